/* design/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/smpq_pkg.sv */
`default_nettype none
package smpq_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OCC_W = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND  = 2'd3;

  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // run the request against the store
    logic step;   // advance a dump by one entry
  } cmd_t;

  typedef struct packed {
    logic last;   // result held in the output register is the final one
  } sts_t;

endpackage
`default_nettype wire

/* design/smpq_intf.sv */
`default_nettype none
interface smpq_in_if;
  import smpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface smpq_out_if;
  import smpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] result_value;
  logic [OCC_W-1:0]        occupancy;
  logic                    last;

  modport source (output valid, status, result_value, occupancy, last, input ready);
  modport sink   (input valid, status, result_value, occupancy, last, output ready);
endinterface
`default_nettype wire

/* design/sorted_min_priority_queue.sv */
// Sorted minimum priority queue holding up to DEPTH signed 32-bit values in
// ascending order in a row of register cells. One request is handled at a
// time: a request is taken in one cycle, executed against the whole row in
// the next, and its result is presented from the cycle after that and held
// until taken; this holds for insert, delete, peek and any request that ends
// in an error. A dump of a non-empty store streams the stored values front
// first, one per cycle while the sink is ready, rotating the row so every
// entry passes the front cell. No new request is accepted until the last
// result of the current one has been taken. The store comes out of reset
// empty and needs no clearing pass; occupancy is reported modulo 16.
`default_nettype none
module sorted_min_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);
  import smpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  smpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_ch.operation),
    .in_value         (in_ch.value),
    .out_status       (out_ch.status),
    .out_result_value (out_ch.result_value),
    .out_occupancy    (out_ch.occupancy),
    .out_last         (out_ch.last)
  );

endmodule
`default_nettype wire

/* design/smpq_ctrl.sv */
`default_nettype none
module smpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output smpq_pkg::cmd_t cmd,
  input  smpq_pkg::sts_t sts
);
  import smpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/smpq_dp.sv */
`default_nettype none
module smpq_dp #(
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smpq_pkg::cmd_t                    cmd,
  output smpq_pkg::sts_t                    sts,
  input  logic [smpq_pkg::OP_W-1:0]         in_operation,
  input  logic signed [smpq_pkg::VAL_W-1:0] in_value,
  output logic [smpq_pkg::ST_W-1:0]         out_status,
  output logic signed [smpq_pkg::VAL_W-1:0] out_result_value,
  output logic [smpq_pkg::OCC_W-1:0]        out_occupancy,
  output logic                              out_last
);
  import smpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] entries_r   [DEPTH];
  logic signed [VAL_W-1:0] entries_nxt [DEPTH];
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           left_r, left_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [ST_W-1:0]         status_r, status_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  logic                    last_r, last_nxt;

  logic [DEPTH-1:0] go;   // cell at or behind the point where val_r belongs
  logic [DEPTH-1:0] eq;
  logic             full, empty, found, rotate;

  // store is sorted, so go is a thermometer code from the insert/delete point
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      go[j] = !(CW'(j) < count_r) || (val_r <= entries_r[j]);
      eq[j] = (CW'(j) < count_r) && (val_r == entries_r[j]);
    end
  end

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign found = |eq;

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    left_nxt    = left_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    res_nxt     = res_r;
    last_nxt    = last_r;
    rotate      = 1'b0;

    if (cmd.load) begin
      op_nxt  = in_operation;
      val_nxt = in_value;
    end

    if (cmd.exec) begin
      status_nxt = ST_OK;
      res_nxt    = '0;
      last_nxt   = 1'b1;
      priority if (op_r == OP_INSERT) begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          if (go[0]) entries_nxt[0] = val_r;
          for (int j = 1; j < DEPTH; j++) begin
            if (go[j]) entries_nxt[j] = go[j-1] ? entries_r[j-1] : val_r;
          end
          count_nxt = count_r + CW'(1);
        end
      end else if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else if (op_r == OP_DELETE) begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          for (int j = 0; j < DEPTH - 1; j++) begin
            if (go[j]) entries_nxt[j] = entries_r[j+1];
          end
          count_nxt = count_r - CW'(1);
          res_nxt   = val_r;
        end
      end else if (op_r == OP_PEEK) begin
        res_nxt = entries_r[0];
      end else begin
        // dump: emit the front and rotate the occupied cells
        res_nxt  = entries_r[0];
        last_nxt = (count_r == CW'(1));
        left_nxt = count_r - CW'(1);
        rotate   = 1'b1;
      end
    end

    if (cmd.step) begin
      res_nxt  = entries_r[0];
      last_nxt = (left_r == CW'(1));
      left_nxt = left_r - CW'(1);
      rotate   = 1'b1;
    end

    // after count rotations the store is back in its original order
    if (rotate) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (CW'(j + 1) < count_r) entries_nxt[j] = entries_r[j+1];
      end
      for (int j = 0; j < DEPTH; j++) begin
        if (CW'(j + 1) == count_r) entries_nxt[j] = entries_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    left_r    <= left_nxt;
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    status_r  <= status_nxt;
    res_r     <= res_nxt;
    last_r    <= last_nxt;
  end

  assign sts.last         = last_r;
  assign out_status       = status_r;
  assign out_result_value = res_r;
  assign out_occupancy    = OCC_W'(count_r);
  assign out_last         = last_r;

endmodule
`default_nettype wire

/* design/smpq_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module smpq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [smpq_pkg::ST_W-1:0]         out_status,
  input logic signed [smpq_pkg::VAL_W-1:0] out_result_value,
  input logic [smpq_pkg::OCC_W-1:0]        out_occupancy,
  input logic                              out_last
);
  import smpq_pkg::*;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_value) && $stable(out_occupancy) && $stable(out_last))

  // one request at a time: the cycle after a transaction is the execute cycle
  `ASSERT_NEXT(a_in_exec, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)

  `ASSERT_IMPLY(a_no_overlap, clk, rst_n, in_ready, !out_valid)

  // only a dump gives more than one result, and all of its results are ok
  `ASSERT_IMPLY(a_multi_ok, clk, rst_n, out_valid && !out_last, out_status == ST_OK)

  `ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_result_value == '0)

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_result_value (out_ch.result_value),
  .out_occupancy    (out_ch.occupancy),
  .out_last         (out_ch.last)
);
`default_nettype wire
